>>> rtl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and codes for the interrupt range translator.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int MAX_RANGES_DEF = 8;
    localparam int SPI_OFFSET     = 32;
    localparam int OP_W           = 2;
    localparam int ENTRY_W        = 3;
    localparam int NUM_W          = 16;
    localparam int CNT_W          = 4;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_P2I  = 2'd1;
    localparam logic [OP_W-1:0] OP_I2P  = 2'd2;

    localparam logic REG_ACTIVE_RANGES = 1'b0;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NOTFOUND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic do_load;
        logic step;
        logic set_hit;
        logic set_miss;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic is_query;
        logic cnt_zero;
        logic hit;
        logic last;
    } t_dp_status;

endpackage

>>> rtl/irt_regs.sv
// ----------------------------------------------------------------------------
// irt_regs
// APB-style register port holding the active range count.
// ----------------------------------------------------------------------------
module irt_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irt_pkg::PADDR_W-1:0]   paddr,
    input  logic [irt_pkg::PDATA_W-1:0]   pwdata,
    output logic [irt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [irt_pkg::CNT_W-1:0]     o_active_ranges
);
    import irt_pkg::*;

    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] n_active;
    logic             sel_active;

    assign sel_active = (paddr[2] == REG_ACTIVE_RANGES);
    assign pready     = 1'b1;

    always_comb begin
        n_active = r_active;
        if (psel && penable && pwrite && pready && sel_active) begin
            n_active = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            r_active <= n_active;
        end
    end

    assign prdata          = sel_active ? {{(PDATA_W-CNT_W){1'b0}}, r_active} : '0;
    assign o_active_ranges = r_active;

endmodule

>>> rtl/irt_ctrl.sv
// ----------------------------------------------------------------------------
// irt_ctrl
// Sequencer: decode, walk the range table, strobe the result.
// ----------------------------------------------------------------------------
module irt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  irt_pkg::t_dp_status   i_status,
    output irt_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);
    import irt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_load) begin
                    o_cmd.do_load = 1'b1;
                    n_state       = S_DONE;
                end else if (i_status.is_query && !i_status.cnt_zero) begin
                    n_state = S_SEARCH;
                end else begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_SEARCH: begin
                if (i_status.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_status.last) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                o_busy  = 1'b0;
                o_valid = 1'b1;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/irt_dp.sv
// ----------------------------------------------------------------------------
// irt_dp
// Range table, item registers and the per-entry range compare.
// ----------------------------------------------------------------------------
module irt_dp #(
    parameter int MAX_RANGES = irt_pkg::MAX_RANGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  irt_pkg::t_dp_cmd              i_cmd,
    output irt_pkg::t_dp_status           o_dp_status,
    input  logic [irt_pkg::CNT_W-1:0]     i_active_ranges,
    input  logic [irt_pkg::OP_W-1:0]      i_op,
    input  logic [irt_pkg::ENTRY_W-1:0]   i_entry_index,
    input  logic [irt_pkg::NUM_W-1:0]     i_pin_base,
    input  logic [irt_pkg::NUM_W-1:0]     i_spi_base,
    input  logic [irt_pkg::NUM_W-1:0]     i_range_size,
    input  logic [irt_pkg::NUM_W-1:0]     i_query,
    output logic                          o_status,
    output logic [irt_pkg::NUM_W-1:0]     o_value
);
    import irt_pkg::*;

    // the table holds no more entries than entry_index can reach
    localparam int ADDRESSABLE = 1 << ENTRY_W;
    localparam int DEPTH = (MAX_RANGES < ADDRESSABLE) ? MAX_RANGES : ADDRESSABLE;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [NUM_W-1:0]   r_pb_tab [DEPTH];
    logic [NUM_W-1:0]   r_sb_tab [DEPTH];
    logic [NUM_W-1:0]   r_sz_tab [DEPTH];

    logic [OP_W-1:0]    r_op;
    logic [ENTRY_W-1:0] r_entry;
    logic [NUM_W-1:0]   r_pb;
    logic [NUM_W-1:0]   r_sb;
    logic [NUM_W-1:0]   r_sz;
    logic [NUM_W-1:0]   r_q;
    logic [IDX_W-1:0]   r_idx;
    logic               r_status;
    logic [NUM_W-1:0]   r_value;

    logic [CNT_W-1:0]   cnt;
    logic [NUM_W-1:0]   e_pb;
    logic [NUM_W-1:0]   e_sb;
    logic [NUM_W-1:0]   e_sz;
    logic [NUM_W:0]     fwd_hi;
    logic [NUM_W:0]     rev_lo;
    logic [NUM_W+1:0]   rev_hi;
    logic               fwd_hit;
    logic               rev_hit;
    logic [NUM_W-1:0]   fwd_val;
    logic [NUM_W-1:0]   rev_val;
    logic               load_ok;

    assign cnt  = (i_active_ranges > DEPTH_C) ? DEPTH_C : i_active_ranges;
    assign e_pb = r_pb_tab[r_idx];
    assign e_sb = r_sb_tab[r_idx];
    assign e_sz = r_sz_tab[r_idx];

    assign fwd_hi  = {1'b0, e_pb} + {1'b0, e_sz};
    assign fwd_hit = (r_op == OP_P2I) && (r_q >= e_pb) && ({1'b0, r_q} < fwd_hi);
    assign fwd_val = e_sb + (r_q - e_pb) + NUM_W'(SPI_OFFSET);

    assign rev_lo  = {1'b0, e_sb} + (NUM_W+1)'(SPI_OFFSET);
    assign rev_hi  = {1'b0, rev_lo} + {2'b00, e_sz};
    assign rev_hit = (r_op == OP_I2P) && ({1'b0, r_q} >= rev_lo) && ({2'b00, r_q} < rev_hi);
    assign rev_val = e_pb + (r_q - e_sb) - NUM_W'(SPI_OFFSET);

    assign load_ok = ({{(CNT_W-ENTRY_W){1'b0}}, r_entry} < DEPTH_C);

    assign o_dp_status.is_load  = (r_op == OP_LOAD);
    assign o_dp_status.is_query = (r_op == OP_P2I) || (r_op == OP_I2P);
    assign o_dp_status.cnt_zero = (cnt == '0);
    assign o_dp_status.hit      = fwd_hit || rev_hit;
    assign o_dp_status.last     = ((CNT_W'(r_idx) + CNT_W'(1)) == cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_pb_tab[i] <= '0;
                r_sb_tab[i] <= '0;
                r_sz_tab[i] <= '0;
            end
        end else if (i_cmd.do_load && load_ok) begin
            r_pb_tab[r_entry[IDX_W-1:0]] <= r_pb;
            r_sb_tab[r_entry[IDX_W-1:0]] <= r_sb;
            r_sz_tab[r_entry[IDX_W-1:0]] <= r_sz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_entry <= i_entry_index;
            r_pb    <= i_pin_base;
            r_sb    <= i_spi_base;
            r_sz    <= i_range_size;
            r_q     <= i_query;
            r_idx   <= '0;
        end else if (i_cmd.step) begin
            r_idx   <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_load) begin
            r_status <= ST_OK;
            r_value  <= '0;
        end else if (i_cmd.set_hit) begin
            r_status <= ST_OK;
            r_value  <= fwd_hit ? fwd_val : rev_val;
        end else if (i_cmd.set_miss) begin
            r_status <= ST_NOTFOUND;
            r_value  <= '0;
        end
    end

    assign o_status = r_status;
    assign o_value  = r_value;

endmodule

>>> rtl/interrupt_range_translator.sv
// ----------------------------------------------------------------------------
// interrupt_range_translator
// Pin to interrupt and interrupt to pin translation over a range table.
// ----------------------------------------------------------------------------
// An item is taken when i_start is high and o_busy is low. Its result shows
// on o_status/o_value for exactly one cycle with o_valid high; there is no
// back-pressure, so the receiver must take it then. For a load or an item that
// searches nothing, the item passes through the decode state and the result
// is strobed from the done state; a query also walks the table in the search
// state, up to the first match or min(active_ranges, entries in table)
// entries. The table is compared one entry per cycle. o_busy drops in the
// strobe cycle, so the next item may start then.
module interrupt_range_translator #(
    parameter int MAX_RANGES = irt_pkg::MAX_RANGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irt_pkg::PADDR_W-1:0]   paddr,
    input  logic [irt_pkg::PDATA_W-1:0]   pwdata,
    output logic [irt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [irt_pkg::OP_W-1:0]      i_op,
    input  logic [irt_pkg::ENTRY_W-1:0]   i_entry_index,
    input  logic [irt_pkg::NUM_W-1:0]     i_pin_base,
    input  logic [irt_pkg::NUM_W-1:0]     i_spi_base,
    input  logic [irt_pkg::NUM_W-1:0]     i_range_size,
    input  logic [irt_pkg::NUM_W-1:0]     i_query,
    output logic                          o_valid,
    output logic                          o_status,
    output logic [irt_pkg::NUM_W-1:0]     o_value
);
    import irt_pkg::*;

    logic [CNT_W-1:0] active_ranges;
    t_dp_cmd          dp_cmd;
    t_dp_status       dp_status;

    irt_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_active_ranges (active_ranges)
    );

    irt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    irt_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_dp_status     (dp_status),
        .i_active_ranges (active_ranges),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_pin_base      (i_pin_base),
        .i_spi_base      (i_spi_base),
        .i_range_size    (i_range_size),
        .i_query         (i_query),
        .o_status        (o_status),
        .o_value         (o_value)
    );

endmodule
